>>> rtl/wenc_pkg.sv
// Shared types, constants and codes for the wheel encoder unwrap estimator.
`timescale 1ns / 1ps
package wenc_pkg;

  // Encoder geometry.
  localparam int COUNTS_PER_TURN = 32768;
  localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

  // 2*pi in Q16.16, and twice that as the divisor for turn rounding.
  localparam logic [19:0] TWO_PI_Q16   = 20'd411775;
  localparam logic [19:0] TURN_DIVISOR = 20'd823550;

  // Quotient bits of the seed turn count: at most 5215 turns.
  localparam int QUOT_W = 13;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ANGLE = 3'd4;

  // Frame classification codes.
  typedef logic [2:0] frame_kind_t;
  localparam frame_kind_t KIND_REJECT = 3'd0;
  localparam frame_kind_t KIND_SEED   = 3'd1;
  localparam frame_kind_t KIND_HOLD   = 3'd2;
  localparam frame_kind_t KIND_INC    = 3'd3;
  localparam frame_kind_t KIND_DEC    = 3'd4;

  typedef struct packed {
    logic        [7:0]  frame_motor_id;
    logic signed [15:0] speed_rpm;
    logic        [15:0] raw_position;
  } wenc_in_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] wheel_angle;
    logic signed [31:0] wheel_rate;
    logic signed [31:0] linear_position;
    logic signed [31:0] linear_speed;
  } wenc_out_t;

  typedef struct packed {
    logic        [7:0]  target_motor_id;
    logic        [15:0] rpm_to_rad_scale;
    logic        [15:0] wheel_radius;
    logic        [30:0] angle_offset;
    logic signed [31:0] initial_angle;
  } wenc_cfg_t;

  typedef struct packed {
    frame_kind_t        kind;
    logic signed [15:0] speed_rpm;
    logic        [15:0] raw_position;
  } wenc_item_t;

endpackage

>>> rtl/wenc_front.sv
// Front end: accepts feedback frames, classifies them and tracks the last position.
`timescale 1ns / 1ps
module wenc_front (
  input  logic                clk,
  input  logic                rst,
  input  wenc_pkg::wenc_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  wenc_pkg::wenc_in_t  in_data,
  input  logic                queue_full,
  output logic                push,
  output wenc_pkg::wenc_item_t push_item
);
  import wenc_pkg::*;

  localparam logic signed [16:0] HALF_S = 17'(HALF_TURN);

  logic               seeded;
  logic [15:0]        previous_position;
  logic signed [16:0] delta;
  frame_kind_t        kind;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;
  assign delta    = $signed({1'b0, in_data.raw_position}) - $signed({1'b0, previous_position});

  always_comb begin
    if (in_data.frame_motor_id != cfg.target_motor_id) begin
      kind = KIND_REJECT;
    end else if (!seeded) begin
      kind = KIND_SEED;
    end else if (delta > HALF_S) begin
      kind = KIND_DEC;
    end else if (delta < -HALF_S) begin
      kind = KIND_INC;
    end else begin
      kind = KIND_HOLD;
    end
  end

  assign push_item.kind         = kind;
  assign push_item.speed_rpm    = in_data.speed_rpm;
  assign push_item.raw_position = in_data.raw_position;

  // Rejected frames leave the position history alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded            <= 1'b0;
      previous_position <= '0;
    end else if (push && kind != KIND_REJECT) begin
      seeded            <= 1'b1;
      previous_position <= in_data.raw_position;
    end
  end

endmodule

>>> rtl/wenc_queue.sv
// Short request queue between the front and the back.
`timescale 1ns / 1ps
module wenc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wenc_pkg::wenc_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output wenc_pkg::wenc_item_t head_item
);
  import wenc_pkg::*;

  wenc_item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/wenc_back.sv
// Back end: turn counter and fixed-point arithmetic on one shared multiplier.
`timescale 1ns / 1ps
module wenc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  wenc_pkg::wenc_cfg_t  cfg,
  input  logic                 head_valid,
  input  wenc_pkg::wenc_item_t head_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wenc_pkg::wenc_out_t  out_data
);
  import wenc_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RATE    = 4'd1;
  localparam logic [3:0] S_BASE    = 4'd2;
  localparam logic [3:0] S_SPEED   = 4'd3;
  localparam logic [3:0] S_TURN    = 4'd4;
  localparam logic [3:0] S_ANGLE   = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_SEEDFIN = 4'd7;
  localparam logic [3:0] S_LIN     = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;
  localparam logic [3:0] S_DIVCHK  = 4'd10;

  // 2^33 / TURN_DIVISOR rounded down; the quotient estimate never runs high.
  localparam logic [20:0] TURN_RECIP = 21'd10430;

  function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
    logic signed [53:0] lim_hi;
    logic signed [53:0] lim_lo;
    lim_hi = 54'sh7FFF_FFFF;
    lim_lo = -54'sh8000_0000;
    if (v > lim_hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lim_lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  logic [3:0]         st;
  wenc_item_t         cur;
  logic [31:0]        turn_count;
  logic signed [31:0] rate;
  logic [31:0]        base;
  logic signed [31:0] speed;
  logic signed [31:0] angle;
  logic signed [53:0] mprod;
  logic [32:0]        rem;
  logic [QUOT_W-1:0]  quot;
  logic               neg;

  logic               mul_en;
  logic signed [32:0] ma;
  logic signed [20:0] mb;

  logic signed [53:0] round_q16;
  logic [53:0]        base_sum;
  logic signed [53:0] angle_sum;
  logic signed [31:0] seed_val;
  logic [31:0]        mag;
  logic [32:0]        rem_left;
  logic [QUOT_W-1:0]  quot_fix;

  // Operand select for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    ma     = '0;
    mb     = '0;
    case (st)
      S_RATE: begin
        mul_en = 1'b1;
        ma     = 33'(cur.speed_rpm);
        mb     = $signed({5'b0, cfg.rpm_to_rad_scale});
      end
      S_BASE: begin
        mul_en = 1'b1;
        ma     = $signed({17'b0, cur.raw_position});
        mb     = $signed({1'b0, TWO_PI_Q16});
      end
      S_SPEED: begin
        mul_en = 1'b1;
        ma     = 33'(rate);
        mb     = $signed({5'b0, cfg.wheel_radius});
      end
      S_TURN: begin
        mul_en = cur.kind != KIND_SEED;
        ma     = $signed({turn_count[31], turn_count});
        mb     = $signed({1'b0, TWO_PI_Q16});
      end
      S_DIV: begin
        mul_en = 1'b1;
        ma     = $signed({13'b0, rem[32:13]});
        mb     = $signed(TURN_RECIP);
      end
      S_DIVCHK: begin
        mul_en = 1'b1;
        ma     = $signed({20'b0, mprod[32:20]});
        mb     = $signed({1'b0, TURN_DIVISOR});
      end
      S_LIN: begin
        mul_en = 1'b1;
        ma     = 33'(angle);
        mb     = $signed({5'b0, cfg.wheel_radius});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Q16 multiply result, rounded half up (arithmetic shift floors).
  assign round_q16 = (mprod + 54'sd32768) >>> 16;
  assign base_sum  = $unsigned(mprod) + 54'(HALF_TURN);
  assign angle_sum = $signed({22'b0, base}) + mprod - $signed({23'b0, cfg.angle_offset});
  assign seed_val  = (cfg.initial_angle != '0) ? cfg.initial_angle : $signed(base);
  assign mag       = seed_val[31] ? 32'(-seed_val) : 32'(seed_val);
  // Remainder left after the quotient estimate; one more divisor means one more turn.
  assign rem_left  = rem - mprod[32:0];
  assign quot_fix  = (rem_left >= 33'(TURN_DIVISOR)) ? quot + 1'b1 : quot;

  assign pop = (st == S_IDLE) && head_valid;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mprod <= ma * mb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      turn_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (st == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (head_valid) begin
            cur <= head_item;
            if (head_item.kind == KIND_INC) begin
              turn_count <= turn_count + 32'd1;
            end else if (head_item.kind == KIND_DEC) begin
              turn_count <= turn_count - 32'd1;
            end
            st <= (head_item.kind == KIND_REJECT) ? S_FIN : S_RATE;
          end
        end
        S_RATE: begin
          st <= S_BASE;
        end
        S_BASE: begin
          rate <= sat32(-mprod);
          st   <= S_SPEED;
        end
        S_SPEED: begin
          base <= 32'(base_sum / COUNTS_PER_TURN);
          st   <= S_TURN;
        end
        S_TURN: begin
          speed <= sat32(round_q16);
          if (cur.kind == KIND_SEED) begin
            // Seed angle goes out as is; count = round(|seed| / 2pi) with sign.
            angle <= seed_val;
            neg   <= seed_val[31];
            rem   <= {mag, 1'b0} + 33'(TWO_PI_Q16);
            st    <= S_DIV;
          end else begin
            st <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          angle <= sat32(angle_sum);
          st    <= S_LIN;
        end
        S_DIV: begin
          // Reciprocal multiply on the top numerator bits; low by at most one.
          st <= S_DIVCHK;
        end
        S_DIVCHK: begin
          // Hold the estimate while its product with the divisor is formed.
          quot <= mprod[32:20];
          st   <= S_SEEDFIN;
        end
        S_SEEDFIN: begin
          turn_count <= neg ? 32'd0 - 32'(quot_fix) : 32'(quot_fix);
          st         <= S_LIN;
        end
        S_LIN: begin
          st <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_FIN && (!out_valid || out_ready)) begin
      if (cur.kind == KIND_REJECT) begin
        out_data <= '0;
      end else begin
        out_data.accepted        <= 1'b1;
        out_data.wheel_angle     <= angle;
        out_data.wheel_rate      <= rate;
        out_data.linear_position <= sat32(round_q16);
        out_data.linear_speed    <= speed;
      end
    end
  end

endmodule

>>> rtl/wheel_encoder_unwrap_estimator_core.sv
// Top level of the wheel encoder unwrap estimator: config registers, front, queue, back.
`timescale 1ns / 1ps
// Takes one motor feedback frame per request (motor id, signed rpm, single-turn
// encoder count) and returns one result per request. Frames for other motor ids
// return accepted=0 with all values zero and leave the state untouched. Wheel
// rate is -rpm * rpm_to_rad_scale (Q16.16 rad/s) and linear speed is that rate
// times wheel_radius. The first accepted frame seeds the turn counter from
// initial_angle, or from the raw position when initial_angle is zero, and
// reports the seed angle without offset; later frames unwrap across the
// half-turn boundary, subtract angle_offset and scale by the radius. All
// outputs saturate to 32 bits; the turn counter wraps. A matched frame runs the
// back-end steps rate, base, speed, turn, angle and linear; the seeding frame runs
// rate, base, speed and turn, then a reciprocal multiply and a check product that
// find the seed turn count, then linear; a rejected frame goes straight to the
// output step. One shared 33x21 multiplier serves one step at a time. A two-entry
// queue lets the front accept frames while the back is busy, and the output
// register holds a finished result while the next frame is worked on.
// Configuration writes take effect at once and must only be made while idle.
module wheel_encoder_unwrap_estimator_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wenc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  wenc_pkg::wenc_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output wenc_pkg::wenc_out_t                  out_data
);
  import wenc_pkg::*;

  wenc_cfg_t  cfg;
  logic       push;
  wenc_item_t push_item;
  logic       queue_full;
  logic       pop;
  logic       head_valid;
  wenc_item_t head_item;

  // Configuration registers; writes to unused indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_motor_id  <= 8'd16;
      cfg.rpm_to_rad_scale <= 16'd6863;
      cfg.wheel_radius     <= 16'd0;
      cfg.angle_offset     <= 31'd809697;
      cfg.initial_angle    <= 32'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_ID:  cfg.target_motor_id  <= cfg_data[7:0];
        CFG_RPM_SCALE:  cfg.rpm_to_rad_scale <= cfg_data[15:0];
        CFG_RADIUS:     cfg.wheel_radius     <= cfg_data[15:0];
        CFG_OFFSET:     cfg.angle_offset     <= cfg_data[30:0];
        CFG_INIT_ANGLE: cfg.initial_angle    <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Classify each request and track seeding and the last position.
  wenc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Hold classified requests until the back end is free.
  wenc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Advance the turn count and compute the outputs.
  wenc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> tb/sv/tb_wheel_encoder_unwrap_estimator_core.sv
// Self-checking testbench for the wheel encoder unwrap estimator core.
`timescale 1ns / 1ps
module tb_wheel_encoder_unwrap_estimator_core;
  import wenc_pkg::*;

  // Encoder and fixed-point constants of the predictor, kept apart from the RTL's own.
  localparam longint TWO_PI    = 411775;
  localparam longint COUNTS    = 32768;
  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;

  // Receiver hold-off used to back the block up, and the watchdog on quiet cycles.
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 220;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  wenc_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  wenc_out_t            out_data;

  wheel_encoder_unwrap_estimator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the configuration registers, starting from their reset values.
  logic [7:0]         tgt_id     = 8'd16;
  logic [15:0]        rpm_scale  = 16'd6863;
  logic [15:0]        radius     = 16'd0;
  logic [30:0]        ang_offset = 31'd809697;
  logic signed [31:0] init_angle = '0;

  // Shadow copy of the unwrap state.
  logic [31:0] turn_cnt = '0;
  logic [15:0] prev_pos = '0;
  logic        seeded   = 1'b0;

  // Frames waiting to be offered, and results predicted for accepted requests.
  wenc_in_t  frame_q[$];
  wenc_out_t result_q[$];

  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        tx_wait     = 0;
  int        rx_wait     = 0;
  int        rx_hold     = 0;
  int        hold_req    = 0;
  int        hold_seen   = 0;
  int        quiet       = 0;
  int        fail_count  = 0;
  int        shown       = 0;
  logic [15:0] walk_pos  = '0;

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Multiply by an unsigned Q0.16 factor, round half up, saturate.
  function automatic longint scale_q16(longint a, logic [15:0] r);
    longint p;
    p = a * longint'({48'd0, r}) + 32768;
    return clamp32(p >>> 16);
  endfunction

  // Predict the result of one accepted frame and advance the shadow state.
  function automatic wenc_out_t predict_frame(wenc_in_t f);
    wenc_out_t r;
    longint    rate, base, angle, seed, mag, turns, delta, lin, speed;
    r = '0;
    if (f.frame_motor_id != tgt_id) return r;
    rate  = clamp32(-(longint'(f.speed_rpm) * longint'({48'd0, rpm_scale})));
    speed = scale_q16(rate, radius);
    base  = (longint'({48'd0, f.raw_position}) * TWO_PI + COUNTS / 2) / COUNTS;
    if (!seeded) begin
      // Seed the turn count, rounding ties away from zero; no offset here.
      seed  = (init_angle != 0) ? longint'(init_angle) : base;
      seed  = longint'($signed(seed[31:0]));
      mag   = (seed < 0) ? -seed : seed;
      turns = (2 * mag + TWO_PI) / (2 * TWO_PI);
      if (seed < 0) turns = -turns;
      turn_cnt = turns[31:0];
      seeded   = 1'b1;
      angle    = seed;
    end else begin
      delta = longint'({48'd0, f.raw_position}) - longint'({48'd0, prev_pos});
      if (delta > COUNTS / 2) turn_cnt = turn_cnt - 32'd1;
      else if (delta < -(COUNTS / 2)) turn_cnt = turn_cnt + 32'd1;
      angle = clamp32(base + longint'($signed(turn_cnt)) * TWO_PI
                      - longint'({33'd0, ang_offset}));
    end
    prev_pos = f.raw_position;
    lin = scale_q16(angle, radius);
    r.accepted        = 1'b1;
    r.wheel_angle     = angle[31:0];
    r.wheel_rate      = rate[31:0];
    r.linear_position = lin[31:0];
    r.linear_speed    = speed[31:0];
    return r;
  endfunction

  function automatic int idle_cycles(int pct);
    if (int'($urandom_range(0, 99)) < pct) return int'($urandom_range(0, 17));
    return 0;
  endfunction

  function automatic wenc_in_t mk_frame(logic [7:0] id, logic [15:0] rpm, logic [15:0] raw);
    wenc_in_t f;
    f.frame_motor_id = id;
    f.speed_rpm      = rpm;
    f.raw_position   = raw;
    return f;
  endfunction

  // Mostly a wheel turning with random steps (some crossing the wrap point),
  // plus frames for other motors and frames with arbitrary fields.
  function automatic wenc_in_t next_frame();
    wenc_in_t f;
    int       pick;
    int       step;
    pick = int'($urandom_range(0, 99));
    f.frame_motor_id = tgt_id;
    case ($urandom_range(0, 11))
      0:       f.speed_rpm = 16'sh8000;
      1:       f.speed_rpm = 16'sh7fff;
      2:       f.speed_rpm = '0;
      default: f.speed_rpm = 16'($urandom);
    endcase
    if (pick < 75) begin
      case ($urandom_range(0, 2))
        0:       step = int'($urandom_range(0, 1000)) - 500;
        1:       step = int'($urandom_range(0, 32768)) - 16384;
        default: step = int'($urandom_range(16385, 32767)) * ($urandom_range(0, 1) ? 1 : -1);
      endcase
      walk_pos = 16'((int'(walk_pos) + step + 32768) % 32768);
      f.raw_position = walk_pos;
    end else if (pick < 88) begin
      f.frame_motor_id = tgt_id ^ 8'($urandom_range(1, 255));
      f.raw_position   = 16'($urandom);
    end else begin
      f.frame_motor_id = $urandom_range(0, 1) ? tgt_id : 8'($urandom);
      f.raw_position   = 16'($urandom);
    end
    return f;
  endfunction

  // Write one register and mirror it; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_TARGET_ID:  tgt_id     = val[7:0];
      CFG_RPM_SCALE:  rpm_scale  = val[15:0];
      CFG_RADIUS:     radius     = val[15:0];
      CFG_OFFSET:     ang_offset = val[30:0];
      CFG_INIT_ANGLE: init_angle = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(logic [7:0] id, logic [15:0] sc, logic [15:0] rad,
                               logic [30:0] off, logic [31:0] ia);
    write_reg(CFG_TARGET_ID, {24'd0, id});
    write_reg(CFG_RPM_SCALE, {16'd0, sc});
    write_reg(CFG_RADIUS, {16'd0, rad});
    write_reg(CFG_OFFSET, {1'b0, off});
    write_reg(CFG_INIT_ANGLE, ia);
  endtask

  // Hold until every queued frame is accepted and every result has come back.
  task automatic wait_drained();
    while (frame_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (shown < 10) begin
        shown++;
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    end
  endtask

  // Request driver: present the next pending frame, hold it until accepted,
  // then idle for the gap drawn for that frame. Predict at the accepting edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else begin
      if (in_valid && in_ready) result_q.push_back(predict_frame(in_data));
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait  <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (frame_q.size() > 0) begin
          in_data  <= frame_q.pop_front();
          in_valid <= 1'b1;
          tx_wait  <= idle_cycles(tx_idle_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted result against the oldest prediction,
  // then stall for a drawn gap. A hold-off request from the sequence holds ready
  // low through a HOLD_CYCLES countdown, so the block fills and stalls its input.
  always @(posedge clk) begin : result_sink
    int        wait_next;
    wenc_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
      rx_hold   <= 0;
      hold_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("result with no request pending: %h", out_data);
          end
        end else begin
          want = result_q.pop_front();
          compare_field("accepted", {31'd0, want.accepted}, {31'd0, out_data.accepted});
          compare_field("wheel_angle", want.wheel_angle, out_data.wheel_angle);
          compare_field("wheel_rate", want.wheel_rate, out_data.wheel_rate);
          compare_field("linear_position", want.linear_position, out_data.linear_position);
          compare_field("linear_speed", want.linear_speed, out_data.linear_speed);
        end
        wait_next = idle_cycles(rx_idle_pct);
      end else begin
        wait_next = (rx_wait > 0) ? rx_wait - 1 : 0;
      end
      rx_wait <= wait_next;
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        rx_hold   <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold   <= rx_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (wait_next == 0);
      end
    end
  end

  // Watchdog: end the run if no request, result or register write moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_wheel_encoder_unwrap_estimator_core failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : run_sequence
    logic [31:0] seed_angle;
    logic [7:0]  t;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Pick how the one seeding frame of the run gets its angle: from the raw
    // position, from either extreme, or from an arbitrary value.
    case ($urandom_range(0, 3))
      0:       seed_angle = 32'd0;
      1:       seed_angle = 32'h8000_0000;
      2:       seed_angle = 32'h7fff_ffff;
      default: seed_angle = $urandom;
    endcase
    load_settings(8'h10, 16'hffff, 16'd40000, 31'd809697, seed_angle);
    t = tgt_id;

    // Directed frames: reject before seeding, seed, field extremes, deltas
    // right at and just past half a turn, positions above one turn, and
    // rejected frames in between that must not disturb the previous position.
    @(negedge clk);
    frame_q.push_back(mk_frame(t ^ 8'h01, 16'd1234, 16'd500));
    frame_q.push_back(mk_frame(t, 16'h8000, 16'd16384));
    frame_q.push_back(mk_frame(t, 16'h7fff, 16'd16500));
    frame_q.push_back(mk_frame(t, 16'h0000, 16'd32767));
    frame_q.push_back(mk_frame(t, 16'hffff, 16'd0));
    frame_q.push_back(mk_frame(8'h00, 16'd100, 16'd40000));
    frame_q.push_back(mk_frame(8'hff, 16'hff9c, 16'hffff));
    frame_q.push_back(mk_frame(t, 16'd1, 16'd16384));
    frame_q.push_back(mk_frame(t, 16'd2, 16'd0));
    frame_q.push_back(mk_frame(t, 16'd3, 16'd16385));
    frame_q.push_back(mk_frame(t, 16'd4, 16'd0));
    frame_q.push_back(mk_frame(t, 16'd5, 16'hffff));
    frame_q.push_back(mk_frame(t, 16'd6, 16'hffff));
    frame_q.push_back(mk_frame(t, 16'hfff9, 16'd100));
    frame_q.push_back(mk_frame(t, 16'd8, 16'd32700));
    frame_q.push_back(mk_frame(t, 16'd9, 16'd200));
    frame_q.push_back(mk_frame(t, 16'h5555, 16'haaaa));
    frame_q.push_back(mk_frame(t, 16'haaaa, 16'h5555));
    frame_q.push_back(mk_frame(8'haa, 16'h0000, 16'h0000));
    frame_q.push_back(mk_frame(8'h55, 16'h7fff, 16'hffff));
    wait_drained();

    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: begin
          load_settings(8'($urandom), 16'($urandom), 16'($urandom),
                        31'($urandom_range(0, 1 << 20)), $urandom);
          tx_idle_pct = 40;
          rx_idle_pct = 40;
        end
        2: begin
          load_settings(8'h00, 16'h0000, 16'h0000, 31'd0, 32'd0);
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        3: begin
          load_settings(8'hff, 16'hffff, 16'hffff, 31'h7fff_ffff, 32'h8000_0000);
          tx_idle_pct = 70;
          rx_idle_pct = 10;
        end
        4: begin
          load_settings(8'($urandom), 16'($urandom), 16'($urandom),
                        31'($urandom), 32'h7fff_ffff);
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        5: begin
          load_settings(8'($urandom), 16'd6863, 16'($urandom), 31'd809697, $urandom);
          tx_idle_pct = 10;
          rx_idle_pct = 70;
        end
        default: begin
          load_settings(8'h10, 16'($urandom), 16'hffff,
                        31'($urandom_range(0, 1 << 22)), 32'd0);
          tx_idle_pct = 50;
          rx_idle_pct = 50;
        end
      endcase
      @(negedge clk);
      if (ph == 4) begin
        // Back the block up: queue the whole phase and hold the receiver off.
        for (int i = 0; i < PHASE_ITEMS; i++) frame_q.push_back(next_frame());
        hold_req = hold_req + 1;
      end else begin
        // Pause the sender halfway until every result is back.
        for (int i = 0; i < PHASE_ITEMS / 2; i++) frame_q.push_back(next_frame());
        wait_drained();
        @(negedge clk);
        for (int i = 0; i < PHASE_ITEMS / 2; i++) frame_q.push_back(next_frame());
      end
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (40) @(posedge clk);
    fail_count += result_q.size();
    if (fail_count == 0) begin
      $display("tb_wheel_encoder_unwrap_estimator_core passed");
    end else begin
      $display("tb_wheel_encoder_unwrap_estimator_core failed");
    end
    $finish;
  end

endmodule
